>>> sv/easing_interpolator_assert.svh
// Assertion macros for the easing interpolator.
`ifndef EASING_INTERPOLATOR_ASSERT_SVH
`define EASING_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define EI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define EI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ei_pkg.sv
// Shared constants and types for the easing interpolator.
package ei_pkg;

    // Parameter defaults
    localparam int EI_COS_DEPTH = 256;
    localparam int EI_FRAC_BITS = 16;

    // Field widths
    localparam int EI_VALUE_W   = 24;
    localparam int EI_DELTA_W   = 16;
    localparam int EI_ELAPSED_W = 25;

    // Curve select codes
    typedef enum logic [1:0] {
        MODE_LINEAR     = 2'd0,
        MODE_SINE       = 2'd1,
        MODE_BOUNCE_IN  = 2'd2,
        MODE_BOUNCE_OUT = 2'd3
    } ei_mode_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_EASING_MODE    = 2'd0;
    localparam logic [1:0] CFG_START_VALUE    = 2'd1;
    localparam logic [1:0] CFG_END_VALUE      = 2'd2;
    localparam logic [1:0] CFG_TOTAL_DURATION = 2'd3;

    // Q30 constants for building the cosine table
    localparam logic [63:0] EI_Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] EI_HALF_PI_Q30 = 64'd1686629713;

endpackage

>>> sv/easing_interpolator.sv
// Easing interpolator top level: serial divide, easing curves, serial multiply.
//
// Each tick transaction adds tick_delta to a saturating 25-bit elapsed time and returns one
// result: start_value + round((end_value - start_value) * ease(elapsed / total_duration)),
// or end_value with finished set once elapsed has passed total_duration (sticky until reset).
// One tick is in flight at a time; tick_ready is high only while the block is idle, and a
// finished result waits in the output register while the next tick is taken. The restoring
// divider produces one progress bit per cycle and the shift-add multiplier consumes one
// multiplier bit per cycle; the bounce curves pass through that multiplier twice. The cosine
// quarter-wave table is a constant ROM with a registered read. Configuration writes are
// always taken and must only be issued while no tick is in flight.
module easing_interpolator
    import ei_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = EI_COS_DEPTH,
    parameter int FRACTION_BITS   = EI_FRAC_BITS
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [EI_VALUE_W-1:0]        cfg_data,
    input  logic                         tick_valid,
    output logic                         tick_ready,
    input  logic [EI_DELTA_W-1:0]        tick_delta,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic signed [EI_VALUE_W-1:0] eased_value,
    output logic                         finished
);

    `include "easing_interpolator_assert.svh"

    localparam int F   = FRACTION_BITS;
    localparam int D   = COS_TABLE_DEPTH;
    localparam int VW  = EI_VALUE_W;
    localparam int EW  = EI_ELAPSED_W;
    localparam int BW  = F + 3;                      // multiplier operand bits
    localparam int MW  = (F + 3 > VW + 1) ? F + 3 : VW + 1;
    localparam int PW  = MW + BW;                    // product register
    localparam int CW  = $clog2(BW);
    localparam int AW  = $clog2(D + 1);
    localparam int UW  = $clog2(2 * D + 1);
    localparam int UPW = F + 2 + UW;
    localparam int SVW = F + 26;

    localparam logic [F:0]     ONE_S    = {1'b1, {F{1'b0}}};
    localparam logic [F+4:0]   LIM4     = (F + 5)'(4) << F;
    localparam logic [F+4:0]   LIM8     = (F + 5)'(8) << F;
    localparam logic [F+4:0]   LIM10    = (F + 5)'(10) << F;
    localparam logic [F+5:0]   OFF12    = (F + 6)'(12) << F;
    localparam logic [F+5:0]   OFF18    = (F + 6)'(18) << F;
    localparam logic [F+5:0]   OFF21    = (F + 6)'(21) << F;
    localparam logic [F:0]     BASE1    = (ONE_S >> 2) * (F + 1)'(3);
    localparam logic [F:0]     BASE2    = (ONE_S >> 4) * (F + 1)'(15);
    localparam logic [F:0]     BASE3    = (ONE_S >> 6) * (F + 1)'(63);
    localparam logic [2*F+6:0] ROUND_SQ = (2 * F + 7)'(32) << F;
    localparam logic [SVW-1:0] SV_HALF  = SVW'(1) << (F - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SIN_U,
        ST_SIN_A,
        ST_SIN_R,
        ST_SIN_E,
        ST_BNC_R,
        ST_BNC_D,
        ST_BNC_T,
        ST_BNC_E,
        ST_MUL_SET,
        ST_MUL,
        ST_POST,
        ST_FIN
    } state_t;

    // Cosine quarter-wave entry in Q(F), Taylor series in Q30
    function automatic logic [FRACTION_BITS:0] cos_entry(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] e;
        longint      r;
        x  = (EI_HALF_PI_Q30 * 64'(idx) + 64'(COS_TABLE_DEPTH / 2)) / COS_TABLE_DEPTH;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        h  = EI_Q30_ONE;
        h  = EI_Q30_ONE - ((x2 * h) >> 30) / 182;
        h  = EI_Q30_ONE - ((x2 * h) >> 30) / 132;
        h  = EI_Q30_ONE - ((x2 * h) >> 30) / 90;
        h  = EI_Q30_ONE - ((x2 * h) >> 30) / 56;
        h  = EI_Q30_ONE - ((x2 * h) >> 30) / 30;
        h  = EI_Q30_ONE - ((x2 * h) >> 30) / 12;
        r  = longint'(EI_Q30_ONE) - longint'(((x2 * h) >> 30) / 2);
        if (r < 0)
        begin
            r = 0;
        end
        e = (64'(r) + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
        if (e > (64'd1 << FRACTION_BITS))
        begin
            e = 64'd1 << FRACTION_BITS;
        end
        return e[FRACTION_BITS:0];
    endfunction

    // Constant cosine ROM
    logic [F:0] cos_rom [0:D];

    for (genvar g = 0; g <= D; g++)
    begin : g_cos
        assign cos_rom[g] = cos_entry(g);
    end

    // Control registers
    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [EW-1:0] elapsed_reg, elapsed_next;
    logic          done_reg, done_next;
    logic          fin_reg, fin_next;
    logic          sq_reg, sq_next;
    ei_mode_t      mode_reg, mode_next;
    logic [VW-1:0] start_reg, start_next;
    logic [VW-1:0] end_reg, end_next;
    logic [VW-1:0] dur_reg, dur_next;
    logic          result_valid_reg, result_valid_next;
    logic [VW-1:0] eased_reg, eased_next;
    logic          finished_reg, finished_next;

    // Datapath registers
    logic [EW-1:0]  rem_reg, rem_next;
    logic [F:0]     quot_reg, quot_next;
    logic [UW-1:0]  u_reg, u_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic           cneg_reg, cneg_next;
    logic [F:0]     cos_reg;
    logic [F+5:0]   pb22_reg, pb22_next;
    logic [1:0]     region_reg, region_next;
    logic [MW-1:0]  mula_reg, mula_next;
    logic [PW-1:0]  prod_reg, prod_next;
    logic [F:0]     t_reg, t_next;
    logic [F:0]     ease_reg, ease_next;
    logic           neg_reg, neg_next;
    logic [SVW-1:0] sv_reg, sv_next;

    // Combinational helpers
    logic [VW-1:0]  dur_eff;
    logic [EW:0]    el_sum;
    logic [EW:0]    div_diff;
    logic           div_bit;
    logic [EW-1:0]  rem_sel;
    logic [MW:0]    mul_sum;
    logic [UPW-1:0] uprod;
    logic [F+1:0]   sin_sum;
    logic [F:0]     pb;
    logic [F+4:0]   p11;
    logic [F+5:0]   off_s;
    logic [F+5:0]   dd_full;
    logic [2*F+6:0] bsum;
    logic [F:0]     base;
    logic [F+1:0]   ebase;
    logic [F:0]     eclamp;
    logic [VW:0]    diff;
    logic [VW:0]    mag;
    logic [SVW-1:0] prodx;

    assign cfg_ready    = 1'b1;
    assign tick_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign eased_value  = eased_reg;
    assign finished     = finished_reg;

    // Next-state and datapath logic
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        elapsed_next      = elapsed_reg;
        done_next         = done_reg;
        fin_next          = fin_reg;
        sq_next           = sq_reg;
        mode_next         = mode_reg;
        start_next        = start_reg;
        end_next          = end_reg;
        dur_next          = dur_reg;
        result_valid_next = result_valid_reg && !result_ready;
        eased_next        = eased_reg;
        finished_next     = finished_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        u_next            = u_reg;
        addr_next         = addr_reg;
        cneg_next         = cneg_reg;
        pb22_next         = pb22_reg;
        region_next       = region_reg;
        mula_next         = mula_reg;
        prod_next         = prod_reg;
        t_next            = t_reg;
        ease_next         = ease_reg;
        neg_next          = neg_reg;
        sv_next           = sv_reg;

        dur_eff  = (dur_reg == '0) ? VW'(1) : dur_reg;
        el_sum   = {1'b0, elapsed_reg} + (EW + 1)'(tick_delta);
        div_diff = {1'b0, rem_reg} - {2'b00, dur_eff};
        div_bit  = !div_diff[EW];
        rem_sel  = div_bit ? div_diff[EW-1:0] : rem_reg;
        mul_sum  = {1'b0, prod_reg[PW-1:BW]} + (prod_reg[0] ? {1'b0, mula_reg} : '0);
        uprod    = UPW'(quot_reg) * UPW'(2 * D) + UPW'(ONE_S >> 1);
        sin_sum  = cneg_reg ? ({1'b0, ONE_S} + {1'b0, cos_reg} + (F + 2)'(1))
                            : ({1'b0, ONE_S} - {1'b0, cos_reg} + (F + 2)'(1));
        pb       = (mode_reg == MODE_BOUNCE_IN) ? (ONE_S - quot_reg) : quot_reg;
        p11      = (F + 5)'(pb) * (F + 5)'(11);
        bsum     = {1'b0, prod_reg[2*F+5:0]} + ROUND_SQ;
        ebase    = {1'b0, t_reg} + {1'b0, base};
        eclamp   = (ebase > {1'b0, ONE_S}) ? ONE_S : ebase[F:0];
        diff     = {end_reg[VW-1], end_reg} - {start_reg[VW-1], start_reg};
        mag      = diff[VW] ? (~diff + (VW + 1)'(1)) : diff;
        prodx    = {1'b0, prod_reg[F+26:2]};

        // Bounce segment offset and base
        unique case (region_reg)
            2'd0:
            begin
                off_s = '0;
                base  = '0;
            end
            2'd1:
            begin
                off_s = OFF12;
                base  = BASE1;
            end
            2'd2:
            begin
                off_s = OFF18;
                base  = BASE2;
            end
            default:
            begin
                off_s = OFF21;
                base  = BASE3;
            end
        endcase
        dd_full = (pb22_reg >= off_s) ? (pb22_reg - off_s) : (off_s - pb22_reg);

        // Configuration writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_EASING_MODE:    mode_next  = ei_mode_t'(cfg_data[1:0]);
                CFG_START_VALUE:    start_next = cfg_data;
                CFG_END_VALUE:      end_next   = cfg_data;
                CFG_TOTAL_DURATION: dur_next   = cfg_data;
                default:            mode_next  = mode_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    elapsed_next = el_sum[EW] ? '1 : el_sum[EW-1:0];
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (done_reg || (elapsed_reg > {1'b0, dur_eff}))
                begin
                    done_next  = 1'b1;
                    fin_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    fin_next   = 1'b0;
                    rem_next   = elapsed_reg;
                    quot_next  = '0;
                    cnt_next   = CW'(F);
                    state_next = ST_DIV;
                end
            end
            // One quotient bit per cycle, MSB first
            ST_DIV:
            begin
                quot_next = {quot_reg[F-1:0], div_bit};
                rem_next  = {rem_sel[EW-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    unique case (mode_reg)
                        MODE_LINEAR:
                        begin
                            ease_next  = {quot_reg[F-1:0], div_bit};
                            state_next = ST_MUL_SET;
                        end
                        MODE_SINE:       state_next = ST_SIN_U;
                        MODE_BOUNCE_IN:  state_next = ST_BNC_R;
                        MODE_BOUNCE_OUT: state_next = ST_BNC_R;
                        default:         state_next = ST_BNC_R;
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            // Sine in-out: table index, fold, read, combine
            ST_SIN_U:
            begin
                u_next     = uprod[F +: UW];
                state_next = ST_SIN_A;
            end
            ST_SIN_A:
            begin
                if (u_reg > UW'(D))
                begin
                    addr_next = AW'(UW'(2 * D) - u_reg);
                    cneg_next = 1'b1;
                end
                else
                begin
                    addr_next = AW'(u_reg);
                    cneg_next = 1'b0;
                end
                state_next = ST_SIN_R;
            end
            ST_SIN_R:
            begin
                state_next = ST_SIN_E;
            end
            ST_SIN_E:
            begin
                ease_next  = sin_sum[F+1:1];
                state_next = ST_MUL_SET;
            end
            // Bounce: pick the segment, then square the offset distance
            ST_BNC_R:
            begin
                pb22_next = {p11, 1'b0};
                priority if (p11 < LIM4)
                begin
                    region_next = 2'd0;
                end
                else if (p11 < LIM8)
                begin
                    region_next = 2'd1;
                end
                else if (p11 < LIM10)
                begin
                    region_next = 2'd2;
                end
                else
                begin
                    region_next = 2'd3;
                end
                state_next = ST_BNC_D;
            end
            ST_BNC_D:
            begin
                mula_next  = MW'(dd_full[F+2:0]);
                prod_next  = PW'(dd_full[F+2:0]);
                cnt_next   = CW'(BW - 1);
                sq_next    = 1'b1;
                state_next = ST_MUL;
            end
            ST_BNC_T:
            begin
                t_next     = bsum[2*F+6:F+6];
                state_next = ST_BNC_E;
            end
            ST_BNC_E:
            begin
                ease_next  = (mode_reg == MODE_BOUNCE_IN) ? (ONE_S - eclamp) : eclamp;
                state_next = ST_MUL_SET;
            end
            // Final scale: |end - start| times the ease factor
            ST_MUL_SET:
            begin
                neg_next   = diff[VW];
                mula_next  = MW'(mag);
                prod_next  = PW'(ease_reg);
                cnt_next   = CW'(F);
                sq_next    = 1'b0;
                state_next = ST_MUL;
            end
            // Shift-add, one multiplier bit per cycle
            ST_MUL:
            begin
                prod_next = {mul_sum, prod_reg[BW-1:1]};
                if (cnt_reg == '0)
                begin
                    state_next = sq_reg ? ST_BNC_T : ST_POST;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            // Restore sign and add half an LSB before the floor shift
            ST_POST:
            begin
                sv_next    = neg_reg ? (~prodx + SV_HALF + SVW'(1)) : (prodx + SV_HALF);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    finished_next     = fin_reg;
                    eased_next        = fin_reg ? end_reg : (start_reg + sv_reg[F+VW-1:F]);
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            elapsed_reg      <= '0;
            done_reg         <= 1'b0;
            fin_reg          <= 1'b0;
            sq_reg           <= 1'b0;
            mode_reg         <= MODE_LINEAR;
            start_reg        <= '0;
            end_reg          <= '0;
            dur_reg          <= VW'(1);
            result_valid_reg <= 1'b0;
            eased_reg        <= '0;
            finished_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            elapsed_reg      <= elapsed_next;
            done_reg         <= done_next;
            fin_reg          <= fin_next;
            sq_reg           <= sq_next;
            mode_reg         <= mode_next;
            start_reg        <= start_next;
            end_reg          <= end_next;
            dur_reg          <= dur_next;
            result_valid_reg <= result_valid_next;
            eased_reg        <= eased_next;
            finished_reg     <= finished_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        u_reg      <= u_next;
        addr_reg   <= addr_next;
        cneg_reg   <= cneg_next;
        pb22_reg   <= pb22_next;
        region_reg <= region_next;
        mula_reg   <= mula_next;
        prod_reg   <= prod_next;
        t_reg      <= t_next;
        ease_reg   <= ease_next;
        neg_reg    <= neg_next;
        sv_reg     <= sv_next;
    end

    // Registered ROM read
    always_ff @(posedge clk)
    begin
        cos_reg <= cos_rom[addr_reg];
    end

    // Checks
    `EI_ASSERT_NXT(a_one_in_flight, tick_valid && tick_ready, !tick_ready, "tick taken while busy")
    `EI_ASSERT_IMP(a_finish_flag, result_valid && finished, done_reg, "finished without done")
    `EI_ASSERT_NXT(a_done_sticky, done_reg, done_reg, "done flag cleared")
    `EI_ASSERT_NXT(a_quot_range, (state_reg == ST_DIV) && (cnt_reg == '0),
                   quot_reg <= ONE_S, "progress above one")

endmodule

>>> tb/sv/easing_interpolator_tb.sv
// Self-checking testbench for the easing interpolator: directed and random ticks, all curves.
module easing_interpolator_tb
    import ei_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = EI_FRAC_BITS;
    localparam longint unsigned SCALE = 64'd1 << FB;
    localparam logic [EI_ELAPSED_W-1:0] ELAPSED_SAT = '1;
    localparam logic [EI_VALUE_W-1:0] DUR_MAX = '1;
    localparam int RANDOM_TICKS_END = 100;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic signed [EI_VALUE_W-1:0] value;
        logic                         done;
    } eased_out_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [1:0]                   cfg_index = CFG_EASING_MODE;
    logic [EI_VALUE_W-1:0]        cfg_data = '0;
    logic                         tick_valid = 1'b0;
    logic                         tick_ready;
    logic [EI_DELTA_W-1:0]        tick_delta = '0;
    logic                         result_valid;
    logic                         result_ready = 1'b0;
    logic signed [EI_VALUE_W-1:0] eased_value;
    logic                         finished;

    // Local copy of the configuration registers and tween state
    ei_mode_t                     cfg_mode = MODE_LINEAR;
    logic signed [EI_VALUE_W-1:0] cfg_start = '0;
    logic signed [EI_VALUE_W-1:0] cfg_end = '0;
    logic [EI_VALUE_W-1:0]        cfg_dur = 24'd1;
    logic [EI_ELAPSED_W-1:0]      tw_elapsed = '0;
    logic                         tw_done = 1'b0;
    longint unsigned              cos_q [0:EI_COS_DEPTH];

    eased_out_t eased_queue [$];
    eased_out_t head;
    int         ticks_sent = 0;
    int         results_seen = 0;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         stall_left = 0;
    bit         jitter_on = 1'b1;

    easing_interpolator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick_delta   (tick_delta),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .eased_value  (eased_value),
        .finished     (finished)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Quarter-wave cosine table, Taylor series in Q30 rounded to FB bits
    initial
    begin : cos_rom
        longint unsigned dens [6];
        longint unsigned x, x2, h, e;
        longint          r;
        int              i, k;
        dens = '{182, 132, 90, 56, 30, 12};
        for (i = 0; i <= EI_COS_DEPTH; i++)
        begin
            x = (EI_HALF_PI_Q30 * 64'(i) + 64'(EI_COS_DEPTH / 2)) / 64'(EI_COS_DEPTH);
            x2 = (x * x + (64'd1 << 29)) >> 30;
            h = EI_Q30_ONE;
            for (k = 0; k < 6; k++)
                h = EI_Q30_ONE - ((x2 * h) >> 30) / dens[k];
            r = longint'(EI_Q30_ONE) - longint'(((x2 * h) >> 30) / 2);
            if (r < 0)
                r = 0;
            e = (64'(r) + (64'd1 << (29 - FB))) >> (30 - FB);
            cos_q[i] = (e > SCALE) ? SCALE : e;
        end
    end

    // Piecewise-parabolic bounce, factor in Q(FB)
    function automatic longint unsigned bounce_out(longint unsigned p);
        longint unsigned off, base, dd, e;
        if (11 * p < 4 * SCALE)
        begin
            off = 0;
            base = 0;
        end
        else if (11 * p < 8 * SCALE)
        begin
            off = 12;
            base = (SCALE * 3) >> 2;
        end
        else if (11 * p < 10 * SCALE)
        begin
            off = 18;
            base = (SCALE * 15) >> 4;
        end
        else
        begin
            off = 21;
            base = (SCALE * 63) >> 6;
        end
        dd = (22 * p >= off * SCALE) ? 22 * p - off * SCALE : off * SCALE - 22 * p;
        e = ((dd * dd + 32 * SCALE) >> (FB + 6)) + base;
        return (e > SCALE) ? SCALE : e;
    endfunction

    // Advance the tween by one tick and return the value it should produce
    function automatic eased_out_t tween_step(logic [EI_DELTA_W-1:0] delta);
        longint unsigned dur, sum, p, e, u;
        longint          diff, v;
        eased_out_t      o;
        dur = (cfg_dur == 0) ? 64'd1 : 64'(cfg_dur);
        sum = 64'(tw_elapsed) + 64'(delta);
        tw_elapsed = (sum > 64'(ELAPSED_SAT)) ? ELAPSED_SAT : EI_ELAPSED_W'(sum);
        if (tw_done || 64'(tw_elapsed) > dur)
        begin
            tw_done = 1'b1;
            o.value = cfg_end;
            o.done = 1'b1;
            return o;
        end
        p = (64'(tw_elapsed) << FB) / dur;
        if (p > SCALE)
            p = SCALE;
        case (cfg_mode)
            MODE_SINE:
            begin
                u = (p * 2 * EI_COS_DEPTH + (SCALE >> 1)) >> FB;
                if (u > 2 * EI_COS_DEPTH)
                    u = 2 * EI_COS_DEPTH;
                if (u <= EI_COS_DEPTH)
                    e = (SCALE - cos_q[u] + 1) >> 1;
                else
                    e = (SCALE + cos_q[2 * EI_COS_DEPTH - u] + 1) >> 1;
            end
            MODE_BOUNCE_IN:  e = SCALE - bounce_out(SCALE - p);
            MODE_BOUNCE_OUT: e = bounce_out(p);
            default:         e = p;
        endcase
        diff = longint'(cfg_end) - longint'(cfg_start);
        v = diff * longint'(e) + longint'(SCALE >> 1);
        o.value = EI_VALUE_W'(longint'(cfg_start) + (v >>> FB));
        o.done = 1'b0;
        return o;
    endfunction

    // Start/end values weighted toward the extremes
    function automatic logic [EI_VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return '0;
            3:       return EI_VALUE_W'($urandom_range(0, 511) - 256);
            default: return EI_VALUE_W'($urandom);
        endcase
    endfunction

    // One register write transaction; the local copy follows on acceptance
    task automatic write_reg(logic [1:0] idx, logic [EI_VALUE_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_EASING_MODE:    cfg_mode = ei_mode_t'(data[1:0]);
            CFG_START_VALUE:    cfg_start = data;
            CFG_END_VALUE:      cfg_end = data;
            CFG_TOTAL_DURATION: cfg_dur = data;
            default:            ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One tick transaction; valid stays up afterward until the next negedge
    task automatic send_tick(logic [EI_DELTA_W-1:0] delta);
        @(negedge clk);
        if (jitter_on && $urandom_range(0, 3) == 0)
        begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        tick_valid <= 1'b1;
        tick_delta <= delta;
        do @(posedge clk); while (!tick_ready);
        eased_queue.push_back(tween_step(delta));
        ticks_sent++;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic settle();
        @(negedge clk);
        tick_valid <= 1'b0;
        while (eased_queue.size() != 0)
            @(posedge clk);
    endtask

    // Duration 0 acts as 1: progress 0 then full
    task automatic test_zero_duration();
        write_reg(CFG_EASING_MODE, EI_VALUE_W'(MODE_LINEAR));
        write_reg(CFG_START_VALUE, 24'd100);
        write_reg(CFG_END_VALUE, 24'd300);
        write_reg(CFG_TOTAL_DURATION, 24'd0);
        send_tick(16'd0);
        send_tick(16'd1);
        settle();
    endtask

    // Each curve at progress near 0, 1/3, 1/2 and 1 over the full value range
    task automatic test_curve_sweep();
        logic [EI_VALUE_W-1:0] sweep_dur [4];
        ei_mode_t              m;
        int                    j;
        sweep_dur = '{DUR_MAX, 24'd3, 24'd2, 24'd1};
        m = m.first();
        do
        begin
            write_reg(CFG_EASING_MODE, EI_VALUE_W'(m));
            write_reg(CFG_START_VALUE, m[0] ? 24'h7FFFFF : 24'h800000);
            write_reg(CFG_END_VALUE, m[0] ? 24'h800000 : 24'h7FFFFF);
            for (j = 0; j < 4; j++)
            begin
                write_reg(CFG_TOTAL_DURATION, sweep_dur[j]);
                send_tick(16'd0);
                settle();
            end
            m = m.next();
        end
        while (m != m.first());
    endtask

    // Random reconfiguration between bursts; deltas never overrun the duration
    task automatic test_random_tween();
        longint unsigned       dur_pick, room;
        logic [EI_DELTA_W-1:0] d;
        int                    n, sel;
        while (ticks_sent < RANDOM_TICKS_END)
        begin
            jitter_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1))
                write_reg(CFG_EASING_MODE, {($urandom_range(0, 1) ? 22'($urandom) : 22'd0),
                                            ei_mode_t'($urandom_range(0, 3))});
            if ($urandom_range(0, 1))
                write_reg(CFG_START_VALUE, pick_value());
            if ($urandom_range(0, 1))
                write_reg(CFG_END_VALUE, pick_value());
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 2))
                    0:       dur_pick = 64'(tw_elapsed) + 64'($urandom_range(0, 32'(tw_elapsed)));
                    1:       dur_pick = 64'(tw_elapsed)
                                        + 64'($urandom_range(0, 32'(16 * tw_elapsed + 64)));
                    default: dur_pick = 64'($urandom_range(32'(tw_elapsed), 32'(DUR_MAX)));
                endcase
                if (dur_pick > 64'(DUR_MAX))
                    dur_pick = 64'(DUR_MAX);
                write_reg(CFG_TOTAL_DURATION, EI_VALUE_W'(dur_pick));
            end
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 2)
                    d = EI_DELTA_W'($urandom);
                else if (sel < 20)
                    d = EI_DELTA_W'($urandom_range(0, 1023));
                else
                    d = EI_DELTA_W'($urandom_range(0, 15));
                room = (64'(cfg_dur) > 64'(tw_elapsed)) ? 64'(cfg_dur) - 64'(tw_elapsed) : 0;
                if (64'(d) > room)
                    d = EI_DELTA_W'(room);
                send_tick(d);
            end
            settle();
        end
    endtask

    // Largest and smallest tick deltas on a long animation
    task automatic test_delta_extremes();
        jitter_on = 1'b1;
        write_reg(CFG_TOTAL_DURATION, DUR_MAX);
        send_tick(16'hFFFF);
        send_tick(16'h0000);
        send_tick(16'hFFFF);
        send_tick(16'h8000);
        send_tick(16'h7FFF);
        settle();
    endtask

    // Elapsed equal to duration is not done; shrinking duration finishes; done sticks
    task automatic test_finish_hold();
        write_reg(CFG_EASING_MODE, EI_VALUE_W'(MODE_BOUNCE_OUT));
        write_reg(CFG_TOTAL_DURATION, EI_VALUE_W'(tw_elapsed));
        send_tick(16'd0);
        settle();
        write_reg(CFG_TOTAL_DURATION, EI_VALUE_W'(tw_elapsed - 1));
        send_tick(16'd0);
        settle();
        write_reg(CFG_TOTAL_DURATION, DUR_MAX);
        send_tick(16'd0);
        settle();
        write_reg(CFG_END_VALUE, pick_value());
        write_reg(CFG_START_VALUE, pick_value());
        send_tick(16'd3);
        settle();
    endtask

    // Drive elapsed into saturation while finished; no idling from here on
    task automatic test_elapsed_saturation();
        int extra;
        int n;
        jitter_on = 1'b0;
        extra = 2;
        while (extra > 0)
        begin
            write_reg(CFG_END_VALUE, pick_value());
            write_reg(CFG_EASING_MODE, EI_VALUE_W'(ei_mode_t'($urandom_range(0, 3))));
            n = 64;
            while (n > 0 && extra > 0)
            begin
                if (tw_elapsed == ELAPSED_SAT)
                    extra--;
                send_tick($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(32768, 65535)));
                n--;
            end
            settle();
        end
    endtask

    // Result side stalls in random bursts; always ready while jitter is off
    always @(negedge clk)
    begin
        if (!rst_n || !jitter_on)
            result_ready <= rst_n;
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            result_ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end
        else
            result_ready <= 1'b1;
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (eased_queue.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing pending: eased_value %0d finished %0b",
                         $time, eased_value, finished);
            end
            else
            begin
                head = eased_queue.pop_front();
                if (eased_value !== head.value)
                begin
                    mismatches++;
                    $display("%0t: eased_value expected %0d actual %0d", $time,
                             $signed(head.value), eased_value);
                end
                if (finished !== head.done)
                begin
                    mismatches++;
                    $display("%0t: finished expected %0b actual %0b", $time,
                             head.done, finished);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, eased_queue.size());
            $display("easing_interpolator test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_zero_duration();
        test_curve_sweep();
        test_random_tween();
        test_delta_extremes();
        test_finish_hold();
        test_elapsed_saturation();
        // Room for any stray late result
        repeat (70) @(posedge clk);
        if (eased_queue.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, eased_queue.size());
        end
        $display("Ran %0d ticks over all four curves: zero, shrunk and full-range durations,",
                 ticks_sent);
        $display("sticky finish and saturated elapsed time; %0d results, %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("easing_interpolator test passed");
        else
            $display("easing_interpolator test failed");
        $finish;
    end

endmodule
